// File: design/hand_axis_ramp_guard_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hand axis ramp guard
// Shared property forms, clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef HAND_AXIS_RAMP_GUARD_UNIT_ASSERT_SVH
`define HAND_AXIS_RAMP_GUARD_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HARG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HARG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/harg_pkg.sv
// ----------------------------------------------------------------------------
// harg_pkg
// Types, register indexes, constants and small arithmetic helpers shared by
// the hand axis ramp guard modules.
// ----------------------------------------------------------------------------
package harg_pkg;

  localparam int AXIS_W    = 2;
  localparam int AXES      = 4;
  localparam int WORD_W    = 24;
  localparam int WIDE_W    = 27;
  localparam int CNT_W     = 7;
  localparam int STEP_W    = 14;
  localparam int REG_IDX_W = 3;
  localparam int BIAS_W    = 24;
  localparam int STEP_RECIP_W = 25;
  localparam int STEP_PROD_W  = BIAS_W + STEP_RECIP_W;
  localparam int DIV3_NUM_W   = 28;
  localparam int DIV3_RECIP_W = 29;
  localparam int DIV3_PROD_W  = DIV3_NUM_W + DIV3_RECIP_W;
  localparam int STEP_SHIFT   = 34;
  localparam int DIV3_SHIFT   = 30;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  localparam logic [AXIS_W-1:0] AXIS_SPREAD = 2'd0;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_SPREAD  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_FINGER1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_FINGER2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_FINGER3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_SPREAD   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_FINGER1  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_FINGER2  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_FINGER3  = 3'd7;

  localparam logic [CNT_W-1:0] STRAIN_LIMIT = 7'd100;

  // Force limits in Q12.12, restore angle in Q4.20.
  localparam wide_t FORCE_HALF        = 27'sd2048;
  localparam wide_t FORCE_QUARTER     = 27'sd1024;
  localparam word_t RESTORE_ANGLE_MAX = 24'sd31457;
  localparam wide_t POS_MAX           = 27'sd8388607;
  localparam wide_t POS_MIN           = -27'sd8388608;

  // Ramp step = round(speed / 1000) = floor((speed + 500) * M >> 34).
  localparam logic [BIAS_W-1:0]       STEP_BIAS  = 24'd500;
  localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 25'd17179870;

  // Floor division by three of a biased, non-negative numerator.
  localparam logic [DIV3_RECIP_W-1:0] DIV3_RECIP = 29'd357913942;
  localparam logic signed [28:0]      DIV3_BIAS  = 29'sd201326592;
  localparam logic [27:0]             DIV3_UNBIAS = 28'd67108864;

  typedef struct packed {
    op_t               op;
    logic [AXIS_W-1:0] axis;
    word_t             angle_first;
    word_t             angle_second;
    word_t             force_first;
    word_t             force_second;
    logic              strained;
  } item_t;

  typedef struct packed {
    word_t            pos;
    logic             clutch_broken;
    word_t            clutch_angle;
    logic [CNT_W-1:0] strain_count;
  } axis_rec_t;

  typedef struct packed {
    word_t                 drive_first;
    word_t                 drive_second;
    logic                  div_sel;
    logic [DIV3_NUM_W-1:0] div_num;
    logic                  drive_valid;
    logic [7:0]            status_word;
    logic                  finger_broken;
  } res_t;

  function automatic word_t sat24(input wide_t v);
    word_t r;
    if (v > POS_MAX) begin
      r = POS_MAX[WORD_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Moves a signed numerator into the non-negative range of the divider.
  function automatic logic [DIV3_NUM_W-1:0] div3_num(input wide_t v);
    logic signed [28:0] t;
    t = 29'(v) + DIV3_BIAS;
    return t[DIV3_NUM_W-1:0];
  endfunction

  // Takes the reciprocal product back to a signed floor quotient.
  function automatic wide_t div3_quot(input logic [DIV3_PROD_W-1:0] prod);
    logic [WIDE_W-1:0] q;
    logic [27:0]       t;
    q = prod[DIV3_PROD_W-1:DIV3_SHIFT];
    t = {1'b0, q} - DIV3_UNBIAS;
    return wide_t'(t[WIDE_W-1:0]);
  endfunction

endpackage

// File: design/harg_axis_ram.sv
// ----------------------------------------------------------------------------
// harg_axis_ram
// Per-axis state memory with a registered read, a bypass from the write port
// and per-entry valid bits that make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module harg_axis_ram import harg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AXIS_W-1:0] rd_axis,
  output axis_rec_t         rd_rec,
  input  logic              wr_en,
  input  logic [AXIS_W-1:0] wr_axis,
  input  axis_rec_t         wr_rec
);

  axis_rec_t       mem [AXES];
  logic [AXES-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_axis] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_axis] <= 1'b1;
    end
  end

  // A write landing on the same edge as the read would otherwise be missed.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_axis == rd_axis)) begin
        rd_rec <= wr_rec;
      end else if (vld[rd_axis]) begin
        rd_rec <= mem[rd_axis];
      end else begin
        rd_rec <= '0;
      end
    end
  end

endmodule

// File: design/harg_cfg_regs.sv
// ----------------------------------------------------------------------------
// harg_cfg_regs
// Target and speed registers, read per item together with the ramp step.
// ----------------------------------------------------------------------------
module harg_cfg_regs import harg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  input  logic                 rd_en,
  input  logic [AXIS_W-1:0]    rd_axis,
  output word_t                tgt,
  output logic [STEP_W-1:0]    step
);

  word_t                  target   [AXES];
  logic [BIAS_W-1:0]      spd_bias [AXES];
  logic [STEP_PROD_W-1:0] step_prod;

  // Speeds are held with the rounding bias already added.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        target[i]   <= '0;
        spd_bias[i] <= STEP_BIAS;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TARGET_SPREAD, REG_TARGET_FINGER1,
        REG_TARGET_FINGER2, REG_TARGET_FINGER3: begin
          target[wr_index[AXIS_W-1:0]] <= word_t'(wr_data);
        end
        REG_SPEED_SPREAD, REG_SPEED_FINGER1,
        REG_SPEED_FINGER2, REG_SPEED_FINGER3: begin
          spd_bias[wr_index[AXIS_W-1:0]] <= BIAS_W'(wr_data[WORD_W-2:0]) + STEP_BIAS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tgt       <= target[rd_axis];
      step_prod <= spd_bias[rd_axis] * STEP_RECIP;
    end
  end

  assign step = step_prod[STEP_SHIFT+STEP_W-1:STEP_SHIFT];

endmodule

// File: design/harg_update.sv
// ----------------------------------------------------------------------------
// harg_update
// Read-modify-write logic for one item: ramp, overcurrent, clutch emulation
// and strain counting, giving the new axis record, status and result.
// ----------------------------------------------------------------------------
module harg_update import harg_pkg::*; (
  input  item_t                  item,
  input  axis_rec_t              rec,
  input  logic [7:0]             status,
  input  word_t                  tgt,
  input  logic [STEP_W-1:0]      step,
  input  logic [DIV3_PROD_W-1:0] seed_prod,
  output axis_rec_t              rec_next,
  output logic [7:0]             status_next,
  output res_t                   res
);

  logic [7:0] idle_bit;
  logic [7:0] oc_bit;
  logic       active;
  logic       move_down;
  logic       move_up;
  wide_t      p_step;
  word_t      p_new;
  logic       arrived;
  wide_t      f_sum;
  wide_t      f_sum_abs;
  wide_t      f_abs1;
  wide_t      f_abs2;
  wide_t      f_abs_sum;
  wide_t      half_sum;
  word_t      seed_pos;

  assign idle_bit  = 8'h01 << item.axis;
  assign oc_bit    = 8'h10 << item.axis;
  assign active    = (status & (idle_bit | oc_bit)) == 8'h00;
  assign move_down = rec.pos > tgt;
  assign move_up   = rec.pos < tgt;
  assign p_step    = move_down ? wide_t'(rec.pos) - wide_t'(step)
                               : wide_t'(rec.pos) + wide_t'(step);
  assign p_new     = (move_down || move_up) ? sat24(p_step) : rec.pos;
  assign arrived   = move_down ? (p_new <= tgt) : (move_up ? (p_new >= tgt) : 1'b0);

  assign f_sum     = wide_t'(item.force_first) + wide_t'(item.force_second);
  assign f_sum_abs = f_sum[WIDE_W-1] ? -f_sum : f_sum;
  assign f_abs1    = item.force_first[WORD_W-1] ? -wide_t'(item.force_first)
                                                : wide_t'(item.force_first);
  assign f_abs2    = item.force_second[WORD_W-1] ? -wide_t'(item.force_second)
                                                 : wide_t'(item.force_second);
  assign f_abs_sum = f_abs1 + f_abs2;
  assign half_sum  = (wide_t'(item.angle_first) + wide_t'(item.angle_second)) >>> 1;
  assign seed_pos  = sat24(wide_t'(item.angle_second) + div3_quot(seed_prod));

  always_comb begin
    logic  cb;
    word_t ca;
    cb          = rec.clutch_broken;
    ca          = rec.clutch_angle;
    rec_next    = rec;
    status_next = status;
    res         = '0;
    unique case (item.op)
      OP_START: begin
        if (item.axis == AXIS_SPREAD) begin
          rec_next.pos = half_sum[WORD_W-1:0];
        end else begin
          rec_next.pos = seed_pos;
        end
        status_next = status & ~(idle_bit | oc_bit);
      end
      OP_TICK: begin
        if (active) begin
          rec_next.pos    = p_new;
          res.drive_valid = 1'b1;
          if (arrived) begin
            status_next = status_next | idle_bit;
          end
          if (item.axis == AXIS_SPREAD) begin
            if (f_sum_abs > FORCE_HALF) begin
              status_next      = status_next | oc_bit;
              res.drive_first  = half_sum[WORD_W-1:0];
              res.drive_second = half_sum[WORD_W-1:0];
            end else begin
              res.drive_first  = p_new;
              res.drive_second = p_new;
            end
          end else begin
            // Closing against a load slips the clutch at the inner angle.
            if (!move_down && (f_abs1 > FORCE_QUARTER)) begin
              ca = item.angle_first;
              cb = 1'b1;
            end
            if (f_abs_sum > FORCE_HALF) begin
              status_next      = status_next | oc_bit;
              res.drive_first  = item.angle_first;
              res.drive_second = item.angle_second;
            end else if (cb) begin
              res.drive_first = ca;
              res.div_sel     = 1'b1;
              res.div_num     = div3_num((wide_t'(p_new) <<< 1) + wide_t'(p_new)
                                         - (wide_t'(ca) <<< 1) + 27'sd1);
              // Opening below the slip angle re-engages the clutch once the inner angle is at most the restore angle.
              if (move_down && (p_new < ca)) begin
                res.drive_first = p_new;
                res.div_num     = div3_num(wide_t'(p_new) + 27'sd1);
                if (item.angle_first <= RESTORE_ANGLE_MAX) begin
                  cb = 1'b0;
                end
              end
            end else begin
              res.drive_first = p_new;
              res.div_sel     = 1'b1;
              res.div_num     = div3_num(wide_t'(p_new) + 27'sd1);
            end
            rec_next.clutch_broken = cb;
            rec_next.clutch_angle  = ca;
          end
        end
        if ((item.axis != AXIS_SPREAD) && (rec.strain_count < STRAIN_LIMIT)) begin
          if (item.strained) begin
            rec_next.strain_count = rec.strain_count + 7'd1;
            res.finger_broken     = (rec.strain_count + 7'd1) >= STRAIN_LIMIT;
          end else begin
            rec_next.strain_count = '0;
          end
        end
      end
    endcase
    res.status_word = status_next;
  end

endmodule

// File: design/harg_drive_out.sv
// ----------------------------------------------------------------------------
// harg_drive_out
// Divide-by-three stage for the outer setpoint and the result register.
// ----------------------------------------------------------------------------
module harg_drive_out import harg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  res_t       in_res,
  output logic       result_valid,
  input  logic       result_stall,
  output word_t      drive_first,
  output word_t      drive_second,
  output logic       drive_valid,
  output logic [7:0] status_word,
  output logic       finger_broken
);

  logic                   v2;
  res_t                   r2;
  logic [DIV3_PROD_W-1:0] prod2;
  logic                   ready3;

  assign ready3   = !result_valid || !result_stall;
  assign in_ready = !v2 || ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v2 <= in_valid;
      end
      if (ready3) begin
        result_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r2    <= in_res;
      prod2 <= in_res.div_num * DIV3_RECIP;
    end
    if (ready3 && v2) begin
      drive_first   <= r2.drive_first;
      drive_second  <= r2.div_sel ? sat24(div3_quot(prod2)) : r2.drive_second;
      drive_valid   <= r2.drive_valid;
      status_word   <= r2.status_word;
      finger_broken <= r2.finger_broken;
    end
  end

endmodule

// File: design/hand_axis_ramp_guard_unit.sv
// ----------------------------------------------------------------------------
// hand_axis_ramp_guard_unit
// Motion supervisor for a four-axis hand: ramps commanded positions, flags
// overcurrent, emulates finger clutches and counts strained ticks.
// ----------------------------------------------------------------------------
// Items enter on the item channel (item_valid, item_stall) and each gives
// exactly one result on the result channel (result_valid, result_stall).
// A start item seeds an axis; a tick item ramps it and issues setpoints.
// Targets and speeds are written through the cfg channel, by the user only
// while the block is idle (the block does not enforce this); cfg_ready is
// high whenever reset is not. The state memory read register loads on the
// accepting edge; the update, write-back and divide-by-three multiply
// complete when the divider stage takes the item, and the quotient fills the
// result register when that register is not held by a stall. The pipeline
// takes a new item every cycle unless stalled; back-to-back items on the same
// axis see the previous write through a bypass on the memory read register.
// Reset clears the axis state memory valid bits, the status word, all
// configuration registers and the pipeline; no clearing pass is needed.
// When the receiver stalls, the result register holds and the two stages
// behind it keep filling, so item_stall rises only once all three are full.
// ----------------------------------------------------------------------------
`include "hand_axis_ramp_guard_unit_assert.svh"

module hand_axis_ramp_guard_unit import harg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 operation,
  input  logic [AXIS_W-1:0]    axis,
  input  word_t                angle_first,
  input  word_t                angle_second,
  input  word_t                force_first,
  input  word_t                force_second,
  input  logic                 strain_exceeded,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output word_t                drive_first,
  output word_t                drive_second,
  output logic                 drive_valid,
  output logic [7:0]           status_word,
  output logic                 finger_broken
);

  logic                   accept;
  logic                   s1_valid;
  logic                   s1_go;
  logic                   s2_ready;
  item_t                  in_item;
  item_t                  s1_item;
  logic [DIV3_PROD_W-1:0] s1_seed_prod;
  axis_rec_t              rd_rec;
  axis_rec_t              rec_next;
  word_t                  tgt_q;
  logic [STEP_W-1:0]      step_q;
  logic [7:0]             axis_status;
  logic [7:0]             status_next;
  res_t                   upd_res;

  // The first stage holds its item until the divider stage can take it.
  assign item_stall = rst || (s1_valid && !s2_ready);
  assign accept     = item_valid && !item_stall;
  assign s1_go      = s1_valid && s2_ready;
  assign cfg_ready  = !rst;

  assign in_item = '{op:           op_t'(operation),
                     axis:         axis,
                     angle_first:  angle_first,
                     angle_second: angle_second,
                     force_first:  force_first,
                     force_second: force_second,
                     strained:     strain_exceeded};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      axis_status <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        axis_status <= status_next;
      end
    end
  end

  // The finger seed needs round(2a/3), so its multiply runs alongside the
  // memory read and is ready when the update sees the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item      <= in_item;
      s1_seed_prod <= div3_num((wide_t'(angle_first) <<< 1) + 27'sd1) * DIV3_RECIP;
    end
  end

  harg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_en    (accept),
    .rd_axis  (axis),
    .tgt      (tgt_q),
    .step     (step_q)
  );

  harg_axis_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_axis (axis),
    .rd_rec  (rd_rec),
    .wr_en   (s1_go),
    .wr_axis (s1_item.axis),
    .wr_rec  (rec_next)
  );

  harg_update u_update (
    .item        (s1_item),
    .rec         (rd_rec),
    .status      (axis_status),
    .tgt         (tgt_q),
    .step        (step_q),
    .seed_prod   (s1_seed_prod),
    .rec_next    (rec_next),
    .status_next (status_next),
    .res         (upd_res)
  );

  harg_drive_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s1_valid),
    .in_ready      (s2_ready),
    .in_res        (upd_res),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .drive_first   (drive_first),
    .drive_second  (drive_second),
    .drive_valid   (drive_valid),
    .status_word   (status_word),
    .finger_broken (finger_broken)
  );

  `HARG_ASSERT_NOW(a_stall_has_item, item_stall, s1_valid, "item stalled with empty first stage")
  `HARG_ASSERT_NEXT(a_start_clears, s1_go && (s1_item.op == OP_START), ((axis_status >> $past(s1_item.axis)) & 8'h11) == 8'h00, "start item left status bits set")
  `HARG_ASSERT_NEXT(a_hold_keeps_item, s1_valid && !s1_go, s1_valid && $stable(s1_item), "held first stage item changed")

endmodule
